// File: hw/rtl/q4hw_pkg.sv
// ----------------------------------------------------------------------------
// q4hw_pkg
// Shared types and constants for the quantized block and fp16 widener.
// ----------------------------------------------------------------------------
package q4hw_pkg;

  // Width of the byte position counter within a block or pair.
  localparam int POS_W = 5;

  // Default count of nibble bytes that follow the scale in one block.
  localparam int NIBBLE_BYTES_DEF = 16;

  // Configuration register map.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_FORMAT_MODE = 2'd0;

  // Values of format_mode.
  localparam logic MODE_BLOCK = 1'b0;
  localparam logic MODE_ARRAY = 1'b1;

  // Values of item_kind.
  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_NIBBLE = 1'b1;

  // Half to single precision exponent handling.
  localparam logic [7:0]  EXP_REBIAS    = 8'd112;
  localparam logic [4:0]  HALF_EXP_MAX  = 5'h1F;
  localparam logic [31:0] SINGLE_EXP_ONES = 32'h7F80_0000;

  // Decision of the position tracker for the byte in flight.
  typedef struct packed {
    logic emit;   // the byte produces a result
    logic kind;   // KIND_WORD or KIND_NIBBLE
    logic last;   // result closes a block or pair
  } res_t;

endpackage

// File: hw/rtl/q4_block_and_half_float_widener_top.sv
// ----------------------------------------------------------------------------
// q4_block_and_half_float_widener_top
// Widens fp16 scales and arrays in a weight byte stream to fp32 words.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_      slave      tdata = data_byte[7:0], tuser = tensor_start
//  out_     master     tdata = item_value[31:0], tuser = item_kind, tlast = block_end
//  cfg_     APB        register 0 at address 0: format_mode (bit 0)
//
//  One byte is accepted per cycle while no out_tready stall holds the stages;
//  a byte's result, if it has one, goes from the input register to the result register.
//  The rate is set by the input register and the result register, with the
//  fp16 conversion and position logic combinational between them.
//  Reset is synchronous and clears the byte position, the held byte and mode.
//  A stall on out_tready holds both stages; in_tready drops once the input register holds a byte.
// ----------------------------------------------------------------------------
module q4_block_and_half_float_widener_top
  import q4hw_pkg::*;
#(
  parameter int NIBBLE_BYTES = NIBBLE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] tensor_start
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [31:0] item_value
  output logic                  out_tuser,  // [0] item_kind
  output logic                  out_tlast,
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic        mode_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_start_r;
  logic        out_valid_r;
  logic        out_kind_r;
  logic        out_last_r;
  logic [31:0] out_value_r;
  logic [31:0] out_value_nxt;
  logic        out_free;
  logic        s1_adv;
  logic        in_fire;
  res_t        res;
  logic [7:0]  held_low_byte;
  logic [31:0] widened;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_FORMAT_MODE) ? {31'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BLOCK;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_FORMAT_MODE) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  // Handshake: the input stage moves whenever the result register can take.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  q4hw_ctrl #(
    .NIBBLE_BYTES(NIBBLE_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (s1_adv),
    .mode         (mode_r),
    .data_byte    (s1_byte_r),
    .tensor_start (s1_start_r),
    .res          (res),
    .held_low_byte(held_low_byte)
  );

  q4hw_widen u_widen (
    .half_in   ({s1_byte_r, held_low_byte}),
    .single_out(widened)
  );

  assign out_value_nxt = (res.kind == KIND_NIBBLE) ? {24'd0, s1_byte_r} : widened;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && res.emit) begin
      out_value_r <= out_value_nxt;
      out_kind_r  <= res.kind;
      out_last_r  <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // A byte waiting in the input register stays put while the output stalls.
  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_start_r))
    else $error("input stage changed during an output stall");

  // Passed nibble bytes carry nothing above bit 7.
  a_nibble_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_NIBBLE |-> out_value_r[31:8] == 24'd0)
    else $error("nibble byte result has upper bits set");

  // A widened word with a zero exponent must be a signed zero.
  a_no_denorm : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_WORD && out_value_r[30:23] == 8'd0
      |-> out_value_r[22:0] == 23'd0)
    else $error("widened word is denormal");

endmodule

// File: hw/rtl/q4hw_widen.sv
// ----------------------------------------------------------------------------
// q4hw_widen
// Combinational conversion of an IEEE half-precision value to single precision.
// ----------------------------------------------------------------------------
module q4hw_widen
  import q4hw_pkg::*;
(
  input  logic [15:0] half_in,
  output logic [31:0] single_out
);

  logic        sign;
  logic [4:0]  expo;
  logic [9:0]  mant;
  logic [3:0]  lead;
  logic [3:0]  shift;
  logic [19:0] mant_wide;
  logic [7:0]  sub_exp;

  assign sign = half_in[15];
  assign expo = half_in[14:10];
  assign mant = half_in[9:0];

  // Position of the leading one of a subnormal mantissa.
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (mant[i]) begin
        lead = 4'(i);
      end
    end
  end

  // The leading one moves to the hidden bit position and is dropped.
  assign shift     = 4'd10 - lead;
  assign mant_wide = {10'd0, mant} << shift;
  assign sub_exp   = EXP_REBIAS + 8'd1 - {4'd0, shift};

  always_comb begin
    if (expo == 5'd0) begin
      if (mant == 10'd0) begin
        single_out = {sign, 31'd0};
      end else begin
        single_out = {sign, sub_exp, mant_wide[9:0], 13'd0};
      end
    end else if (expo == HALF_EXP_MAX) begin
      single_out = {sign, 31'd0} | SINGLE_EXP_ONES | {9'd0, mant, 13'd0};
    end else begin
      single_out = {sign, {3'd0, expo} + EXP_REBIAS, mant, 13'd0};
    end
  end

endmodule

// File: hw/rtl/q4hw_ctrl.sv
// ----------------------------------------------------------------------------
// q4hw_ctrl
// Byte position tracker: holds the low scale byte and classifies each byte.
// ----------------------------------------------------------------------------
module q4hw_ctrl
  import q4hw_pkg::*;
#(
  parameter int NIBBLE_BYTES = NIBBLE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic       mode,
  input  logic [7:0] data_byte,
  input  logic       tensor_start,
  output res_t       res,
  output logic [7:0] held_low_byte
);

  localparam logic [POS_W:0] BLOCK_LEN = (POS_W+1)'(NIBBLE_BYTES + 2);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [POS_W-1:0] pos;
  logic [POS_W:0]   pos_inc;

  always_comb begin
    pos      = tensor_start ? '0 : pos_r;
    pos_nxt  = pos_r;
    held_nxt = held_r;
    pos_inc  = '0;
    res      = '{emit: 1'b0, kind: KIND_WORD, last: 1'b0};
    if (mode == MODE_ARRAY) begin
      if (pos == '0) begin
        held_nxt = data_byte;
        pos_nxt  = POS_W'(1);
      end else begin
        res     = '{emit: 1'b1, kind: KIND_WORD, last: 1'b1};
        pos_nxt = '0;
      end
    end else begin
      // A position at or past the block end restarts the block.
      if ({1'b0, pos} >= BLOCK_LEN) begin
        pos = '0;
      end
      if (pos == '0) begin
        held_nxt = data_byte;
        pos_nxt  = POS_W'(1);
      end else if (pos == POS_W'(1)) begin
        res     = '{emit: 1'b1, kind: KIND_WORD, last: 1'b0};
        pos_nxt = POS_W'(2);
      end else begin
        res.emit = 1'b1;
        res.kind = KIND_NIBBLE;
        pos_inc  = {1'b0, pos} + (POS_W+1)'(1);
        if (pos_inc >= BLOCK_LEN) begin
          res.last = 1'b1;
          pos_nxt  = '0;
        end else begin
          pos_nxt  = pos_inc[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      held_r <= '0;
    end else if (fire) begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
    end
  end

  assign held_low_byte = held_r;

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quantized block and fp16 widener.
// A byte stream is driven in block and array mode with random gaps and result
// stalls. A scoreboard tracks the byte position and computes each expected
// fp32 word or nibble byte, then compares it with what the block returns.
// ----------------------------------------------------------------------------
module tb;
  import q4hw_pkg::*;

  localparam int BLOCK_BYTES    = NIBBLE_BYTES_DEF + 2;
  localparam int RESULT_LATENCY = 2;
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 6;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASES         = 8;
  localparam int RANDOM_BYTES   = 1100;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        last;
  } widened_item_t;

  class widen_scoreboard;
    logic            array_mode;
    logic [4:0]      byte_pos;
    logic [7:0]      low_byte;
    widened_item_t   expected_q[$];
    int              error_count;

    function new();
      array_mode  = MODE_BLOCK;
      byte_pos    = '0;
      low_byte    = '0;
      error_count = 0;
    endfunction

    function void set_mode(logic m);
      array_mode = m;
    endfunction

    function logic [31:0] half_to_single(logic [15:0] h);
      logic [10:0] mant;
      logic [7:0]  expo;
      logic [31:0] word;
      mant = {1'b0, h[9:0]};
      if (h[14:10] == 5'd0) begin
        if (h[9:0] == 10'd0) begin
          word = {h[15], 31'd0};
        end else begin
          // A subnormal is shifted up until the hidden bit appears, and the
          // exponent drops by one for every shift.
          expo = EXP_REBIAS + 8'd1;
          while (!mant[10]) begin
            mant = mant << 1;
            expo = expo - 8'd1;
          end
          word = {h[15], expo, mant[9:0], 13'd0};
        end
      end else if (h[14:10] == HALF_EXP_MAX) begin
        word = {h[15], 31'd0} | SINGLE_EXP_ONES | {9'd0, h[9:0], 13'd0};
      end else begin
        word = {h[15], {3'b000, h[14:10]} + EXP_REBIAS, h[9:0], 13'd0};
      end
      return word;
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      logic [4:0]    pos;
      widened_item_t r;
      pos = start ? 5'd0 : byte_pos;
      if (array_mode == MODE_ARRAY) begin
        if (pos == 5'd0) begin
          low_byte = b;
          byte_pos = 5'd1;
        end else begin
          r.kind  = KIND_WORD;
          r.value = half_to_single({b, low_byte});
          r.last  = 1'b1;
          expected_q.push_back(r);
          byte_pos = 5'd0;
        end
        return;
      end
      if (pos >= BLOCK_BYTES) pos = 5'd0;
      if (pos == 5'd0) begin
        low_byte = b;
        byte_pos = 5'd1;
      end else if (pos == 5'd1) begin
        r.kind  = KIND_WORD;
        r.value = half_to_single({b, low_byte});
        r.last  = 1'b0;
        expected_q.push_back(r);
        byte_pos = 5'd2;
      end else begin
        r.kind  = KIND_NIBBLE;
        r.value = {24'd0, b};
        r.last  = (int'(pos) + 1 >= BLOCK_BYTES);
        expected_q.push_back(r);
        byte_pos = r.last ? 5'd0 : pos + 5'd1;
      end
    endfunction

    function void check_result(logic kind, logic [31:0] value, logic last);
      widened_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d value=%h last=%0d",
                 $time, kind, value, last);
        error_count++;
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: item_kind expected %0d actual %0d", $time, e.kind, kind);
        error_count++;
      end
      if (value !== e.value) begin
        $display("%0t: item_value expected %h actual %h", $time, e.value, value);
        error_count++;
      end
      if (last !== e.last) begin
        $display("%0t: block_end expected %0d actual %0d", $time, e.last, last);
        error_count++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  widen_scoreboard sb;
  logic            in_no_gaps    = 1'b0;
  logic            out_no_stalls = 1'b0;
  int              stall_left    = 0;
  int              cycle_count   = 0;

  q4_block_and_half_float_widener_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: check every transaction, then hold tready low for a
  // randomly drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tuser, out_tdata, out_tlast);
        stall_left = out_no_stalls ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b, start);
    gap = in_no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_half(input logic [15:0] h, input logic start);
    send_byte(h[7:0], start);
    send_byte(h[15:8], 1'b0);
  endtask

  // Lets the pipeline drain: every expected result must have come back, and
  // a held byte may still be in flight after that.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_FORMAT_MODE;
    cfg_pwdata  <= {31'd0, m};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_mode(m);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Biased toward zero, subnormals, infinity and NaN.
  function automatic logic [15:0] rand_half();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 7))
      0: h[14:0] = 15'd0;
      1: h[14:10] = 5'd0;
      2: h[14:10] = HALF_EXP_MAX;
      3: begin
        h[14:10] = 5'd0;
        h[9:0]   = 10'd1 << $urandom_range(0, 9);
      end
      default: ;
    endcase
    return h;
  endfunction

  initial begin
    int         phase;
    int         sent;
    int         k;
    int         unit_len;
    logic [7:0] unit_bytes [BLOCK_BYTES];
    logic [15:0] h;
    logic       new_tensor;
    logic       mode;

    sb = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One full block with a negative zero scale and extreme nibble bytes.
    write_mode(MODE_BLOCK);
    send_half(16'h8000, 1'b1);
    for (k = 2; k < BLOCK_BYTES; k++) begin
      send_byte(k == 2 ? 8'h00 : (k == 3 ? 8'hFF : 8'($urandom)), 1'b0);
    end
    // A tensor start in the middle of a block drops the partial block.
    send_half(16'h3C00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_half(16'h0001, 1'b1);
    send_byte(8'h5A, 1'b0);
    // Switching to array mode mid-block: the next byte completes a pair with
    // the held low byte of the last scale.
    wait_idle();
    write_mode(MODE_ARRAY);
    send_byte(8'h7C, 1'b0);
    send_half(16'hFFFF, 1'b0);
    send_half(16'hFC00, 1'b0);
    send_half(16'h03FF, 1'b0);
    send_byte(8'h12, 1'b0);
    send_half(16'h7BFF, 1'b1);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      mode = phase[0] ? MODE_ARRAY : MODE_BLOCK;
      write_mode(mode);
      in_no_gaps    = (phase == 3) || ($urandom_range(0, 3) == 0);
      out_no_stalls = (phase == 3) || ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < RANDOM_BYTES / PHASES) begin
        h = rand_half();
        unit_bytes[0] = h[7:0];
        unit_bytes[1] = h[15:8];
        if (mode == MODE_ARRAY) begin
          unit_len = ($urandom_range(0, 15) == 0) ? 1 : 2;
        end else begin
          for (k = 2; k < BLOCK_BYTES; k++) unit_bytes[k] = 8'($urandom);
          unit_len = ($urandom_range(0, 9) == 0) ?
                     $urandom_range(1, BLOCK_BYTES - 1) : BLOCK_BYTES;
        end
        new_tensor = ($urandom_range(0, 7) == 0);
        for (k = 0; k < unit_len; k++) begin
          send_byte(unit_bytes[k],
                    (k == 0 && new_tensor) || ($urandom_range(0, 63) == 0));
          sent++;
        end
      end
    end

    wait_idle();
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/q4hw_pkg.sv
hw/rtl/q4hw_widen.sv
hw/rtl/q4hw_ctrl.sv
hw/rtl/q4_block_and_half_float_widener_top.sv
tb/tb.sv
